[design/laminar_flame_speed_egr_macros.svh]
// ----------------------------------------------------------------------------
// laminar flame speed assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef LAMINAR_FLAME_SPEED_EGR_MACROS_SVH
`define LAMINAR_FLAME_SPEED_EGR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold
`define LFS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[design/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// types, constants and table generators for the laminar flame speed pipeline
// ----------------------------------------------------------------------------
package lfs_pkg;

	localparam int unsigned PHI_W = 40;
	localparam int unsigned LOG_W = 23;

	localparam logic [16:0] ONE_075   = 17'd70451;
	localparam logic [17:0] LOG2_E    = 18'd94548;
	localparam logic [23:0] OUT_MAX   = 24'hFFFFFF;

	typedef enum logic [2:0] {
		REG_SPEED_SCALE   = 3'd0,
		REG_PHI_EXPONENT  = 3'd1,
		REG_GAUSS_WIDTH   = 3'd2,
		REG_DILUTION      = 3'd3,
		REG_TEMP_EXPONENT = 3'd4,
		REG_PRESS_EXP     = 3'd5,
		REG_FIXED_PHI     = 3'd6,
		REG_STOICH_AFR    = 3'd7
	} cfg_reg_t;

	// side data riding along the divider
	typedef struct packed {
		logic [23:0]        p;
		logic [15:0]        tu;
		logic               fixed;
		logic signed [33:0] dil;
	} fe_side_t;

	// side data riding along the exp2 product chain
	typedef struct packed {
		logic signed [6:0] ip;
		logic [31:0]       dil;
		logic              force_out;
		logic              force_sat;
		logic              force_flag;
	} ex_side_t;

	// log2 of a Q30 mantissa in 1..2, Q16, by square and compare
	function automatic logic [16:0] log_cell(input logic [63:0] m0);
		logic [63:0] m;
		logic [16:0] r;
		m = m0;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			r = r << 1;
			if (m >= (64'd1 << 31)) begin
				r[0] = 1'b1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	// 2^(2^-(16-k)) style roots in Q30, the constant used for fraction bit k
	function automatic logic [30:0] exp2_root(input int k);
		logic [63:0] c;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		c = 64'd1 << 31;
		for (int j = 15; j >= 0; j--) begin
			if (j >= k) begin
				n = c << 30;
				res = '0;
				b = 64'd1 << 62;
				for (int t = 0; t < 32; t++) begin
					if (n >= res + b) begin
						n = n - (res + b);
						res = (res >> 1) + b;
					end else begin
						res = res >> 1;
					end
					b = b >> 2;
				end
				c = res;
			end
		end
		return c[30:0];
	endfunction

endpackage

[design/lfs_div.sv]
// ----------------------------------------------------------------------------
// lfs_div
// pipelined restoring divider for the mixture-mode equivalence ratio
// ----------------------------------------------------------------------------
`include "laminar_flame_speed_egr_macros.svh"

module lfs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [lfs_pkg::PHI_W-1:0] num,
	input  logic [16:0]               den,
	input  lfs_pkg::fe_side_t         in_side,
	output logic                      out_valid,
	output logic [lfs_pkg::PHI_W-1:0] quot,
	output lfs_pkg::fe_side_t         out_side
);

	localparam int unsigned QW  = lfs_pkg::PHI_W;
	localparam int unsigned BPS = 4;
	localparam int unsigned NST = QW / BPS;

	logic              v_s    [NST];
	logic [16:0]       rem_s  [NST];
	logic [16:0]       den_s  [NST];
	logic [QW-1:0]     n_s    [NST];
	logic [QW-1:0]     q_s    [NST];
	lfs_pkg::fe_side_t side_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic              v_i;
		logic [16:0]       rem_i;
		logic [16:0]       den_i;
		logic [QW-1:0]     n_i;
		logic [QW-1:0]     q_i;
		lfs_pkg::fe_side_t side_i;
		logic [16:0]       rem_c;
		logic [QW-1:0]     n_c;
		logic [QW-1:0]     q_c;
		logic [17:0]       t;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign den_i  = den;
			assign n_i    = num;
			assign q_i    = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign den_i  = den_s[g-1];
			assign n_i    = n_s[g-1];
			assign q_i    = q_s[g-1];
			assign side_i = side_s[g-1];
		end

		// one quotient bit per step, msb first
		always_comb begin
			rem_c = rem_i;
			n_c   = n_i;
			q_c   = q_i;
			t     = '0;
			for (int b = 0; b < BPS; b++) begin
				t   = {rem_c, n_c[QW-1]};
				n_c = n_c << 1;
				if (t >= {1'b0, den_i}) begin
					rem_c = 17'(t - {1'b0, den_i});
					q_c   = {q_c[QW-2:0], 1'b1};
				end else begin
					rem_c = t[16:0];
					q_c   = {q_c[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_c;
				den_s[g]  <= den_i;
				n_s[g]    <= n_c;
				q_s[g]    <= q_c;
				side_s[g] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign quot      = q_s[NST-1];
	assign out_side  = side_s[NST-1];

	`LFS_ASSERT_IMP(a_rem_below_den, v_s[NST-1], rem_s[NST-1] < den_s[NST-1],
		"divider remainder not below divisor")

endmodule

[design/lfs_log2.sv]
// ----------------------------------------------------------------------------
// lfs_log2
// four stage log2 unit: leading one, normalize, table lookup, interpolate
// ----------------------------------------------------------------------------
module lfs_log2 #(
	parameter int unsigned IN_W  = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [IN_W-1:0]           x,
	output logic [lfs_pkg::LOG_W-1:0] lg
);

	localparam int unsigned IDX_W = $clog2(DEPTH + 1);

	logic [16:0] tbl [DEPTH+1];

	for (genvar g = 0; g <= DEPTH; g++) begin : g_tbl
		if (g == DEPTH) begin : g_end
			assign tbl[g] = 17'd65536;
		end else begin : g_cell
			localparam logic [63:0] M0 = (64'd1 << 30) + ((64'(g) << 30) / DEPTH);
			assign tbl[g] = lfs_pkg::log_cell(M0);
		end
	end

	logic [5:0]       e_c;
	logic [5:0]       e_s1;
	logic [IN_W-1:0]  x_s1;
	logic [63:0]      xn;
	logic [5:0]       e_s2;
	logic [31:0]      frac_s2;
	logic [63:0]      pos;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] idx1;
	logic [5:0]       e_s3;
	logic [16:0]      t0_s3;
	logic [16:0]      t1_s3;
	logic [15:0]      rem_s3;
	logic [32:0]      slope;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (x[i]) e_c = 6'(i);
		end
	end

	assign xn    = 64'(x_s1) << (6'd63 - e_s1);
	assign pos   = 64'(frac_s2) * 64'(DEPTH);
	assign idx   = pos[32 +: IDX_W];
	assign idx1  = idx + IDX_W'(1);
	assign slope = 33'(t1_s3 - t0_s3) * 33'(rem_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= e_c;
			x_s1    <= x;
			e_s2    <= e_s1;
			frac_s2 <= xn[62:31];
			e_s3    <= e_s2;
			t0_s3   <= tbl[idx];
			t1_s3   <= tbl[idx1];
			rem_s3  <= pos[31:16];
			lg      <= lfs_pkg::LOG_W'({e_s3, 16'd0}) + lfs_pkg::LOG_W'(t0_s3)
				+ lfs_pkg::LOG_W'(slope >> 16);
		end
	end

endmodule

[design/lfs_exp2.sv]
// ----------------------------------------------------------------------------
// lfs_exp2
// exp2 of a Q16 fraction as a chain of sixteen root multiplies, one per stage
// ----------------------------------------------------------------------------
`include "laminar_flame_speed_egr_macros.svh"

module lfs_exp2 (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [15:0]       fr,
	input  lfs_pkg::ex_side_t in_side,
	output logic              out_valid,
	output logic [30:0]       mant,
	output lfs_pkg::ex_side_t out_side
);

	localparam int unsigned NST = 16;

	logic              v_s    [NST];
	logic [15:0]       fr_s   [NST];
	logic [30:0]       m_s    [NST];
	lfs_pkg::ex_side_t side_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		localparam int KB = NST - 1 - g;
		localparam logic [30:0] ROOT = lfs_pkg::exp2_root(KB);

		logic              v_i;
		logic [15:0]       fr_i;
		logic [30:0]       m_i;
		lfs_pkg::ex_side_t side_i;
		logic [61:0]       p;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign fr_i   = fr;
			assign m_i    = 31'd1 << 30;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_s[g-1];
			assign fr_i   = fr_s[g-1];
			assign m_i    = m_s[g-1];
			assign side_i = side_s[g-1];
		end

		assign p = 62'(m_i) * 62'(ROOT);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fr_s[g]   <= fr_i;
				m_s[g]    <= fr_i[KB] ? 31'(p >> 30) : m_i;
				side_s[g] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign mant      = m_s[NST-1];
	assign out_side  = side_s[NST-1];

	`LFS_ASSERT_NEVER(a_mant_range, v_s[NST-1] && !m_s[NST-1][30],
		"exp2 mantissa below one")

endmodule

[design/laminar_flame_speed_egr.sv]
// ----------------------------------------------------------------------------
// laminar_flame_speed_egr
// laminar flame speed with exhaust gas dilution, fully pipelined
// ----------------------------------------------------------------------------
// Input stream s_axis carries one cell per transaction: pressure, unburnt
// temperature, fuel fraction and residual fraction packed in tdata. Output
// stream m_axis returns one transaction per cell, in order: flame speed in
// tdata, clamp or saturate flag in tuser.
// Config is written over cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write only while the pipeline is empty.
// A cell travels from the input transaction to m_axis_tvalid through 36
// register stages: one input stage, ten divider stages (four
// quotient bits each), one phi select stage, four log2 stages, two exponent
// and sum stages, sixteen exp2 multiply stages and two output stages.
// Throughput is one cell per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the default coefficients.
// When the receiver stalls the whole pipeline holds, and s_axis_tready drops
// only while a result sits unaccepted at the output.
// ----------------------------------------------------------------------------
`include "laminar_flame_speed_egr_macros.svh"

module laminar_flame_speed_egr #(
	parameter int unsigned LOG_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pressure[23:0], unburnt_temperature[39:24], fuel_fraction[55:40],
	// residual_fraction[71:56]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// flame_speed[23:0]
	output logic [23:0] m_axis_tdata,
	// speed_clamped[0]
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int unsigned LW = lfs_pkg::LOG_W;

	typedef struct packed {
		logic        tz;
		logic        pz;
		logic [31:0] dil;
		logic        force_out;
		logic        force_sat;
		logic        force_flag;
	} mid_t;

	// configuration
	logic [19:0]        speed_scale_q;
	logic signed [15:0] phi_exp_q;
	logic signed [15:0] gauss_q;
	logic signed [15:0] dil_f_q;
	logic signed [15:0] temp_exp_q;
	logic signed [15:0] press_exp_q;
	logic [15:0]        fixed_phi_q;
	logic [15:0]        afr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q <= 20'd27656;
			phi_exp_q     <= 16'sd614;
			gauss_q       <= 16'sd21217;
			dil_f_q       <= 16'sd9421;
			temp_exp_q    <= 16'sd8929;
			press_exp_q   <= -16'sd655;
			fixed_phi_q   <= 16'd4096;
			afr_q         <= 16'd3840;
		end else if (cfg_valid) begin
			unique case (lfs_pkg::cfg_reg_t'(cfg_index))
				lfs_pkg::REG_SPEED_SCALE:   speed_scale_q <= cfg_data;
				lfs_pkg::REG_PHI_EXPONENT:  phi_exp_q     <= cfg_data[15:0];
				lfs_pkg::REG_GAUSS_WIDTH:   gauss_q       <= cfg_data[15:0];
				lfs_pkg::REG_DILUTION:      dil_f_q       <= cfg_data[15:0];
				lfs_pkg::REG_TEMP_EXPONENT: temp_exp_q    <= cfg_data[15:0];
				lfs_pkg::REG_PRESS_EXP:     press_exp_q   <= cfg_data[15:0];
				lfs_pkg::REG_FIXED_PHI:     fixed_phi_q   <= cfg_data[15:0];
				lfs_pkg::REG_STOICH_AFR:    afr_q         <= cfg_data[15:0];
			endcase
		end
	end

	// whole pipeline advances together
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: unpack, dilution term, divider operands
	logic [23:0]        in_p;
	logic [15:0]        in_tu;
	logic [15:0]        in_ft;
	logic [15:0]        in_res;
	logic               in_fixed;
	logic [15:0]        res_eff;
	logic signed [32:0] fres;

	assign in_p     = s_axis_tdata[23:0];
	assign in_tu    = s_axis_tdata[39:24];
	assign in_ft    = s_axis_tdata[55:40];
	assign in_res   = s_axis_tdata[71:56];
	assign in_fixed = fixed_phi_q != 16'd0;
	assign res_eff  = in_fixed ? 16'd0 : in_res;
	assign fres     = 33'(dil_f_q) * 33'($signed({1'b0, res_eff}));

	logic              v_s1;
	lfs_pkg::fe_side_t side_s1;
	logic [31:0]       num_s1;
	logic [16:0]       den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.p     <= in_p;
			side_s1.tu    <= in_tu;
			side_s1.fixed <= in_fixed;
			side_s1.dil   <= 34'sd268435456 - 34'(fres);
			num_s1        <= 32'(afr_q) * 32'(in_ft);
			den_s1        <= 17'd65536 - 17'(in_ft);
		end
	end

	// divider
	logic                      dv_valid;
	logic [lfs_pkg::PHI_W-1:0] dv_quot;
	lfs_pkg::fe_side_t         dv_side;

	lfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.num      ({num_s1, 8'd0}),
		.den      (den_s1),
		.in_side  (side_s1),
		.out_valid(dv_valid),
		.quot     (dv_quot),
		.out_side (dv_side)
	);

	// stage 2: select phi, decide special outcomes
	logic [lfs_pkg::PHI_W-1:0] phi_c;
	logic                      zero_c;
	logic                      inf_c;
	logic                      tz_c;
	logic                      pz_c;
	mid_t                      mid_c;

	always_comb begin
		phi_c  = dv_side.fixed ? lfs_pkg::PHI_W'({fixed_phi_q, 4'd0}) : dv_quot;
		tz_c   = dv_side.tu == 16'd0;
		pz_c   = dv_side.p == 24'd0;
		zero_c = (phi_c == '0) || (speed_scale_q == 20'd0)
			|| (tz_c && temp_exp_q > 16'sd0) || (pz_c && press_exp_q > 16'sd0);
		inf_c  = (tz_c && temp_exp_q < 16'sd0) || (pz_c && press_exp_q < 16'sd0);
		mid_c.tz         = tz_c;
		mid_c.pz         = pz_c;
		mid_c.dil        = dv_side.dil[31:0];
		mid_c.force_out  = 1'b1;
		mid_c.force_sat  = 1'b0;
		mid_c.force_flag = 1'b0;
		if (zero_c) begin
			mid_c.force_sat  = 1'b0;
		end else if (inf_c) begin
			mid_c.force_sat  = dv_side.dil > 34'sd0;
			mid_c.force_flag = dv_side.dil != 34'sd0;
		end else if (dv_side.dil <= 34'sd0) begin
			mid_c.force_flag = dv_side.dil < 34'sd0;
		end else begin
			mid_c.force_out  = 1'b0;
		end
	end

	logic                      v_s2;
	logic [lfs_pkg::PHI_W-1:0] phi_s2;
	logic [23:0]               p_s2;
	logic [15:0]               tu_s2;
	mid_t                      mid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s2 <= phi_c;
			p_s2   <= dv_side.p;
			tu_s2  <= dv_side.tu;
			mid_s2 <= mid_c;
		end
	end

	// stages 3 to 6: four log2 units in parallel with the gaussian term
	logic [LW-1:0] lg_w;
	logic [LW-1:0] lg_phi;
	logic [LW-1:0] lg_tu;
	logic [LW-1:0] lg_p;

	lfs_log2 #(.IN_W(20), .DEPTH(LOG_TABLE_DEPTH)) u_log_w (
		.clk(clk), .en(en), .x(speed_scale_q), .lg(lg_w)
	);
	lfs_log2 #(.IN_W(lfs_pkg::PHI_W), .DEPTH(LOG_TABLE_DEPTH)) u_log_phi (
		.clk(clk), .en(en), .x(phi_s2), .lg(lg_phi)
	);
	lfs_log2 #(.IN_W(16), .DEPTH(LOG_TABLE_DEPTH)) u_log_tu (
		.clk(clk), .en(en), .x(tu_s2), .lg(lg_tu)
	);
	lfs_log2 #(.IN_W(24), .DEPTH(LOG_TABLE_DEPTH)) u_log_p (
		.clk(clk), .en(en), .x(p_s2), .lg(lg_p)
	);

	logic signed [40:0] gd;
	logic [40:0]        gad;
	logic [57:0]        gsq;
	logic signed [57:0] gxp;
	logic signed [63:0] gep;

	assign gd  = $signed({1'b0, phi_s2}) - 41'sd70451;
	assign gad = gd < 41'sd0 ? 41'(-gd) : 41'(gd);

	logic [28:0]        ad_s3;
	logic [40:0]        d2_s4;
	logic signed [45:0] gx_s5;
	logic signed [47:0] gt_s6;

	assign gsq = 58'(ad_s3) * 58'(ad_s3);
	assign gxp = 58'(gauss_q) * 58'($signed({1'b0, d2_s4}));
	assign gep = 64'(gx_s5) * 64'($signed({1'b0, lfs_pkg::LOG2_E}));

	logic v_s3, v_s4, v_s5, v_s6;
	mid_t mid_s3, mid_s4, mid_s5, mid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// distance from 1.075 capped at 2^28
			ad_s3  <= gad > 41'(29'h1000_0000) ? 29'h1000_0000 : 29'(gad);
			d2_s4  <= 41'(gsq >> 16);
			gx_s5  <= 46'(gxp >>> 12);
			gt_s6  <= 48'(gep >>> 16);
			mid_s3 <= mid_s2;
			mid_s4 <= mid_s3;
			mid_s5 <= mid_s4;
			mid_s6 <= mid_s5;
		end
	end

	// stage 7: exponent products
	logic signed [23:0] lphi_d;
	logic signed [23:0] ltu_d;
	logic signed [23:0] lp_d;
	logic signed [39:0] eta_p;
	logic signed [39:0] alpha_p;
	logic signed [39:0] beta_p;

	assign lphi_d  = $signed({1'b0, lg_phi}) - 24'sd1048576;
	assign ltu_d   = $signed({1'b0, lg_tu}) - 24'sd801428;
	assign lp_d    = $signed({1'b0, lg_p}) - 24'sd1089751;
	assign eta_p   = 40'(phi_exp_q) * 40'(lphi_d);
	assign alpha_p = 40'(temp_exp_q) * 40'(ltu_d);
	assign beta_p  = 40'(press_exp_q) * 40'(lp_d);

	logic               v_s7;
	mid_t               mid_s7;
	logic signed [23:0] lw_s7;
	logic signed [27:0] et_s7;
	logic signed [27:0] at_s7;
	logic signed [27:0] bt_s7;
	logic signed [47:0] gt_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s7 <= mid_s6;
			lw_s7  <= $signed({1'b0, lg_w}) - 24'sd1048576;
			et_s7  <= 28'(eta_p >>> 12);
			at_s7  <= mid_s6.tz ? 28'sd0 : 28'(alpha_p >>> 12);
			bt_s7  <= mid_s6.pz ? 28'sd0 : 28'(beta_p >>> 12);
			gt_s7  <= gt_s6;
		end
	end

	// stage 8: log sum and clamp
	logic signed [48:0]   lsum;
	logic signed [LW-1:0] l_c;

	always_comb begin
		lsum = 49'(lw_s7) + 49'(et_s7) - 49'(gt_s7) + 49'(at_s7) + 49'(bt_s7);
		if (lsum < -49'sd4194304) begin
			l_c = -23'sd4194304;
		end else if (lsum > 49'sd4194303) begin
			l_c = 23'sd4194303;
		end else begin
			l_c = LW'(lsum);
		end
	end

	logic                 v_s8;
	logic signed [LW-1:0] l_s8;
	mid_t                 mid_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s8   <= l_c;
			mid_s8 <= mid_s7;
		end
	end

	lfs_pkg::ex_side_t ex_in;
	lfs_pkg::ex_side_t ex_out;
	logic              ex_valid;
	logic [30:0]       ex_mant;

	assign ex_in.ip         = l_s8[LW-1:16];
	assign ex_in.dil        = mid_s8.dil;
	assign ex_in.force_out  = mid_s8.force_out;
	assign ex_in.force_sat  = mid_s8.force_sat;
	assign ex_in.force_flag = mid_s8.force_flag;

	lfs_exp2 u_exp2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.fr       (l_s8[15:0]),
		.in_side  (ex_in),
		.out_valid(ex_valid),
		.mant     (ex_mant),
		.out_side (ex_out)
	);

	// stage 9: scale by dilution
	logic              v_s9;
	logic [62:0]       prod_s9;
	lfs_pkg::ex_side_t side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= ex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s9 <= 63'(ex_mant) * 63'(ex_out.dil);
			side_s9 <= ex_out;
		end
	end

	// stage 10: final shift, saturation and output register
	logic [6:0]  sh;
	logic [62:0] shifted;
	logic [23:0] speed_c;
	logic        clamp_c;

	assign sh      = 7'(7'sd42 - side_s9.ip);
	assign shifted = prod_s9 >> sh;

	always_comb begin
		if (side_s9.force_out) begin
			speed_c = side_s9.force_sat ? lfs_pkg::OUT_MAX : 24'd0;
			clamp_c = side_s9.force_flag;
		end else if (side_s9.ip >= 7'sd42) begin
			// mantissa times dilution is at least 2^30, so any left shift overflows
			speed_c = lfs_pkg::OUT_MAX;
			clamp_c = 1'b1;
		end else if (shifted > 63'(lfs_pkg::OUT_MAX)) begin
			speed_c = lfs_pkg::OUT_MAX;
			clamp_c = 1'b1;
		end else begin
			speed_c = shifted[23:0];
			clamp_c = 1'b0;
		end
	end

	logic        v_s10;
	logic [23:0] speed_s10;
	logic        clamp_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s10 <= speed_c;
			clamp_s10 <= clamp_c;
		end
	end

	assign m_axis_tvalid   = v_s10;
	assign m_axis_tdata    = speed_s10;
	assign m_axis_tuser[0] = clamp_s10;

	`LFS_ASSERT_IMP(a_clamp_ends, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata == 24'd0 || m_axis_tdata == lfs_pkg::OUT_MAX,
		"clamp flag set on a value that is neither zero nor full scale")
	`LFS_ASSERT_IMP(a_zero_phi_forced, v_s2 && phi_s2 == '0,
		mid_s2.force_out && !mid_s2.force_sat && !mid_s2.force_flag,
		"zero equivalence ratio not forced to a plain zero")

endmodule
